FILE: src/bal_pkg.sv
// bal_pkg: types and constants shared by the bounded array list table
// request and response words, opcodes, cell token and pass flags, controller states
// no dependencies
`default_nettype none

package bal_pkg;

   localparam int OPCODE_W = 3;
   localparam int IDX_W    = 4;
   localparam int DATA_W   = 32;
   localparam int CNT_W    = 5;
   localparam int CAP_W    = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND = 3'd0,
      OP_READ   = 3'd1,
      OP_REMOVE = 3'd2,
      OP_SEARCH = 3'd3,
      OP_CLEAR  = 3'd4
   } op_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [IDX_W-1:0]    entry_index;
      logic [DATA_W-1:0]   entry_data;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [DATA_W-1:0] read_data;
      logic [IDX_W-1:0]  found_index;
      logic [CNT_W-1:0]  entry_count;
   } rsp_type;

   // travels from cell to cell along with the carried entry and index
   typedef struct packed {
      logic valid;
      logic hit;
   } token_type;

   // what the current pass does, held for the whole pass and seen by every cell
   typedef struct packed {
      logic append;
      logic read;
      logic remove;
      logic move;
      logic search;
   } pass_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage

`default_nettype wire

FILE: src/bounded_array_list_table.sv
// bounded_array_list_table: top level, controller plus a row of ENTRY_COUNT cells
// depends on bal_pkg, bal_ctrl and bal_cell
`default_nettype none

// Fixed-capacity list of ENTRY_COUNT entries held one per cell in a row of cells.
// Every word (append, read, remove, search, clear) sends one token down the row from
// the highest cell to cell 0, one cell per cycle; cells write, pick up or compare their
// entry as it passes, and the result is formed once the token has left cell 0 at the end
// of the cell row. One word is in flight at a time; a finished result sits in an output
// register so the next word may be taken before it is read.
// capacity_limit (csr_data) is taken on any cycle, saturates at ENTRY_COUNT and resets to 16.
// Entries are not cleared at reset; only entries below the count are ever looked at.
module bounded_array_list_table #(
   parameter int ENTRY_COUNT = 16,
   parameter int ENTRY_WIDTH = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire bal_pkg::req_type            req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output bal_pkg::rsp_type                 rsp_data,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [bal_pkg::CAP_W-1:0]   csr_data
);
   import bal_pkg::*;

   localparam int IW = $clog2(ENTRY_COUNT);
   localparam int CW = $clog2(ENTRY_COUNT+1);

   pass_type               pass;
   logic [ENTRY_WIDTH-1:0] key;
   logic [IW-1:0]          tail_pos, tgt_pos;
   logic [CW-1:0]          count;

   // element ENTRY_COUNT is the launch point, element 0 leaves the last cell
   token_type              tok_chain   [ENTRY_COUNT+1];
   logic [ENTRY_WIDTH-1:0] carry_chain [ENTRY_COUNT+1];
   logic [IW-1:0]          hidx_chain  [ENTRY_COUNT+1];

   bal_ctrl #(
      .ENTRY_COUNT (ENTRY_COUNT),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .pass         (pass),
      .key          (key),
      .tail_pos     (tail_pos),
      .tgt_pos      (tgt_pos),
      .count        (count),
      .launch_tok   (tok_chain[ENTRY_COUNT]),
      .launch_carry (carry_chain[ENTRY_COUNT]),
      .launch_hidx  (hidx_chain[ENTRY_COUNT]),
      .ret_tok      (tok_chain[0]),
      .ret_carry    (carry_chain[0]),
      .ret_hidx     (hidx_chain[0])
   );

   for (genvar g = 0; g < ENTRY_COUNT; g++) begin : g_cell
      bal_cell #(
         .ENTRY_COUNT (ENTRY_COUNT),
         .ENTRY_WIDTH (ENTRY_WIDTH),
         .POSITION    (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .pass      (pass),
         .key       (key),
         .tail_pos  (tail_pos),
         .tgt_pos   (tgt_pos),
         .count     (count),
         .tok_in    (tok_chain[g+1]),
         .carry_in  (carry_chain[g+1]),
         .hidx_in   (hidx_chain[g+1]),
         .tok_out   (tok_chain[g]),
         .carry_out (carry_chain[g]),
         .hidx_out  (hidx_chain[g])
      );
   end

endmodule

`default_nettype wire

FILE: src/bal_cell.sv
// bal_cell: one table entry plus one stage of the token chain
// depends on bal_pkg for the token and pass types
`default_nettype none

module bal_cell #(
   parameter int ENTRY_COUNT = 16,
   parameter int ENTRY_WIDTH = 32,
   parameter int POSITION    = 0
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire bal_pkg::pass_type                  pass,
   input  wire logic [ENTRY_WIDTH-1:0]             key,
   input  wire logic [$clog2(ENTRY_COUNT)-1:0]     tail_pos,
   input  wire logic [$clog2(ENTRY_COUNT)-1:0]     tgt_pos,
   input  wire logic [$clog2(ENTRY_COUNT+1)-1:0]   count,
   input  wire bal_pkg::token_type                 tok_in,
   input  wire logic [ENTRY_WIDTH-1:0]             carry_in,
   input  wire logic [$clog2(ENTRY_COUNT)-1:0]     hidx_in,
   output bal_pkg::token_type                      tok_out,
   output logic [ENTRY_WIDTH-1:0]                  carry_out,
   output logic [$clog2(ENTRY_COUNT)-1:0]          hidx_out
);
   import bal_pkg::*;

   localparam int IW = $clog2(ENTRY_COUNT);
   localparam int CW = $clog2(ENTRY_COUNT+1);
   localparam logic [IW-1:0] POS_I = IW'(POSITION);
   localparam logic [CW-1:0] POS_C = CW'(POSITION);

   logic [ENTRY_WIDTH-1:0] entry_ff, entry_in;
   token_type              tok_ff, tok_in_n;
   logic [ENTRY_WIDTH-1:0] carry_ff, carry_in_n;
   logic [IW-1:0]          hidx_ff, hidx_in_n;
   logic                   at_tail, at_tgt, live;

   assign at_tail = (tail_pos == POS_I);
   assign at_tgt  = (tgt_pos == POS_I);
   assign live    = (POS_C < count);

   always_comb begin
      entry_in   = entry_ff;
      tok_in_n   = tok_in;
      carry_in_n = carry_in;
      hidx_in_n  = hidx_in;
      if (tok_in.valid) begin
         if (pass.append && at_tail) begin
            entry_in = key;
         end
         // last entry is picked up here, before the token reaches the hole
         if (pass.remove && at_tail) begin
            carry_in_n = entry_ff;
         end
         if (pass.remove && pass.move && at_tgt) begin
            entry_in = carry_in;
         end
         if (pass.read && at_tgt) begin
            carry_in_n   = entry_ff;
            tok_in_n.hit = 1'b1;
         end
         // token runs downwards, so a lower match overwrites a higher one
         if (pass.search && live && (entry_ff == key)) begin
            carry_in_n   = entry_ff;
            tok_in_n.hit = 1'b1;
            hidx_in_n    = POS_I;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_n;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      carry_ff <= carry_in_n;
      hidx_ff  <= hidx_in_n;
   end

   assign tok_out   = tok_ff;
   assign carry_out = carry_ff;
   assign hidx_out  = hidx_ff;

endmodule

`default_nettype wire

FILE: src/bal_ctrl.sv
// bal_ctrl: handshakes, capacity register, fill count and pass sequencing
// depends on bal_pkg; launches a token into the cell chain and collects it at the far end
`default_nettype none

module bal_ctrl #(
   parameter int ENTRY_COUNT = 16,
   parameter int ENTRY_WIDTH = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire bal_pkg::req_type                   req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output bal_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [bal_pkg::CAP_W-1:0]          csr_data,
   output bal_pkg::pass_type                       pass,
   output logic [ENTRY_WIDTH-1:0]                  key,
   output logic [$clog2(ENTRY_COUNT)-1:0]          tail_pos,
   output logic [$clog2(ENTRY_COUNT)-1:0]          tgt_pos,
   output logic [$clog2(ENTRY_COUNT+1)-1:0]        count,
   output bal_pkg::token_type                      launch_tok,
   output logic [ENTRY_WIDTH-1:0]                  launch_carry,
   output logic [$clog2(ENTRY_COUNT)-1:0]          launch_hidx,
   input  wire bal_pkg::token_type                 ret_tok,
   input  wire logic [ENTRY_WIDTH-1:0]             ret_carry,
   input  wire logic [$clog2(ENTRY_COUNT)-1:0]     ret_hidx
);
   import bal_pkg::*;

   localparam int IW = $clog2(ENTRY_COUNT);
   localparam int CW = $clog2(ENTRY_COUNT+1);
   localparam int XW = (CW > IDX_W) ? CW : IDX_W;
   localparam int AW = (CW > CAP_W) ? CW : CAP_W;
   localparam int MW = (ENTRY_WIDTH > DATA_W) ? ENTRY_WIDTH : DATA_W;
   localparam logic [AW-1:0] FULL = AW'(ENTRY_COUNT);

   state_type             state_ff, state_in;
   logic [CAP_W-1:0]      cap_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic                  launch_ff, launch_in;
   pass_type              pass_ff, pass_in;
   logic [ENTRY_WIDTH-1:0] key_ff, key_in;
   logic [IW-1:0]         tail_ff, tail_in;
   logic [IW-1:0]         tgt_ff, tgt_in;
   logic                  search_ff, search_in;
   logic                  res_ok_ff, res_ok_in;
   logic [IDX_W-1:0]      res_idx_ff, res_idx_in;
   rsp_type               fin_ff, fin_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  accept;
   logic [AW-1:0]         cnt_a, cap_a, eff_cap;
   logic                  app_ok, idx_ok, move;
   logic [XW-1:0]         idx_x, cnt_x, last_x, hidx_x;
   logic [CW-1:0]         last;
   logic [MW-1:0]         data_ext, carry_ext;
   logic [ENTRY_WIDTH-1:0] data_key;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign cnt_a   = AW'(count_ff);
   assign cap_a   = AW'(cap_ff);
   assign eff_cap = (cap_a > FULL) ? FULL : cap_a;
   assign app_ok  = (cnt_a < eff_cap);

   assign idx_x  = XW'(req_data.entry_index);
   assign cnt_x  = XW'(count_ff);
   assign last   = count_ff - 1'b1;
   assign last_x = XW'(last);
   assign idx_ok = (idx_x < cnt_x);
   assign move   = (idx_x < last_x);

   assign data_ext  = MW'(req_data.entry_data);
   assign data_key  = data_ext[ENTRY_WIDTH-1:0];
   assign carry_ext = MW'(ret_carry);
   assign hidx_x    = XW'(ret_hidx);

   always_comb begin
      count_in   = count_ff;
      launch_in  = 1'b0;
      pass_in    = pass_ff;
      key_in     = key_ff;
      tail_in    = tail_ff;
      tgt_in     = tgt_ff;
      search_in  = search_ff;
      res_ok_in  = res_ok_ff;
      res_idx_in = res_idx_ff;
      if (accept) begin
         launch_in  = 1'b1;
         pass_in    = '0;
         key_in     = data_key;
         tgt_in     = idx_x[IW-1:0];
         search_in  = 1'b0;
         res_ok_in  = 1'b0;
         res_idx_in = '0;
         case (op_type'(req_data.opcode))
            OP_APPEND: begin
               if (app_ok) begin
                  pass_in.append = 1'b1;
                  tail_in        = count_ff[IW-1:0];
                  count_in       = count_ff + 1'b1;
                  res_ok_in      = 1'b1;
                  res_idx_in     = cnt_x[IDX_W-1:0];
               end
            end
            OP_READ: begin
               if (idx_ok) begin
                  pass_in.read = 1'b1;
                  res_ok_in    = 1'b1;
                  res_idx_in   = req_data.entry_index;
               end
            end
            OP_REMOVE: begin
               if (idx_ok) begin
                  pass_in.remove = 1'b1;
                  pass_in.move   = move;
                  tail_in        = last[IW-1:0];
                  count_in       = last;
                  res_ok_in      = 1'b1;
                  res_idx_in     = req_data.entry_index;
               end
            end
            OP_SEARCH: begin
               pass_in.search = 1'b1;
               search_in      = 1'b1;
            end
            OP_CLEAR: begin
               count_in  = '0;
               res_ok_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // result assembly once the token leaves cell 0
   always_comb begin
      fin_in             = fin_ff;
      fin_in.ok          = search_ff ? ret_tok.hit : res_ok_ff;
      fin_in.read_data   = ret_tok.hit ? carry_ext[DATA_W-1:0] : '0;
      fin_in.found_index = search_ff ? (ret_tok.hit ? hidx_x[IDX_W-1:0] : '0) : res_idx_ff;
      fin_in.entry_count = cnt_a[CNT_W-1:0];
      if (!((state_ff == ST_SCAN) && ret_tok.valid)) begin
         fin_in = fin_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (ret_tok.valid) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = fin_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pass_ff    <= pass_in;
      key_ff     <= key_in;
      tail_ff    <= tail_in;
      tgt_ff     <= tgt_in;
      search_ff  <= search_in;
      res_ok_ff  <= res_ok_in;
      res_idx_ff <= res_idx_in;
      fin_ff     <= fin_in;
      rsp_ff     <= rsp_in;
   end

   assign pass     = pass_ff;
   assign key      = key_ff;
   assign tail_pos = tail_ff;
   assign tgt_pos  = tgt_ff;
   assign count    = count_ff;

   assign launch_tok.valid = launch_ff;
   assign launch_tok.hit   = 1'b0;
   assign launch_carry     = '0;
   assign launch_hidx      = '0;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
